@@ hw/rtl/dstq_pkg.sv @@
`timescale 1ns / 1ps

package dstq_pkg;

	// Sizing
	localparam int THREADS     = 16;
	localparam int MAX_RESULTS = 16;
	localparam int ID_W        = 4;
	localparam int TICK_W      = 32;
	localparam int IDX_W       = (THREADS > 1) ? $clog2(THREADS) : 1;
	localparam int CMP_W       = ((IDX_W > ID_W) ? IDX_W : ID_W) + 1;
	localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

	// Result kinds
	typedef enum logic [1:0] {
		KIND_ACK  = 2'd0,
		KIND_WAKE = 2'd1,
		KIND_IDLE = 2'd2
	} kind_t;

	// Control states
	typedef enum logic {
		ST_IDLE = 1'b0,
		ST_POP  = 1'b1
	} state_t;

	// One list entry held by a cell; delta is relative to the entry before it
	typedef struct packed {
		logic              valid;
		logic [ID_W-1:0]   id;
		logic [TICK_W-1:0] delta;
	} entry_t;

	// Insertion token moving down the chain.
	// disp = 0: still searching, t is the remaining wait.
	// disp = 1: carrying a displaced entry, t is its delta.
	typedef struct packed {
		logic              valid;
		logic              disp;
		logic [ID_W-1:0]   id;
		logic [TICK_W-1:0] t;
	} tok_t;

	// Commands from the controller to the chain: pop to every cell, dec to the head only
	typedef struct packed {
		logic pop;
		logic dec;
	} head_ctl_t;

endpackage

@@ hw/rtl/dstq_in_if.sv @@
`timescale 1ns / 1ps

interface dstq_in_if;
	logic                       valid;
	logic                       ready;
	logic                       op;
	logic [dstq_pkg::ID_W-1:0]   thread_id;
	logic [dstq_pkg::TICK_W-1:0] ticks;

	modport source (output valid, output op, output thread_id, output ticks, input ready);
	modport sink   (input valid, input op, input thread_id, input ticks, output ready);
endinterface

@@ hw/rtl/dstq_out_if.sv @@
`timescale 1ns / 1ps

interface dstq_out_if;
	logic                       valid;
	logic                       ready;
	logic [1:0]                 kind;
	logic [dstq_pkg::ID_W-1:0]   woken_thread;
	logic [dstq_pkg::TICK_W-1:0] time_now;
	logic                       last;

	modport source (output valid, output kind, output woken_thread, output time_now,
		output last, input ready);
	modport sink   (input valid, input kind, input woken_thread, input time_now,
		input last, output ready);
endinterface

@@ hw/rtl/delta_sleep_timer_queue.sv @@
`timescale 1ns / 1ps
// Sleep request: acknowledged in the cycle after acceptance; the insertion token then
//   walks the cell chain one cell per cycle, so the next request waits until the token has left the chain.
// Tick request: the controller enters the pop state, which registers the first result; then one
//   woken thread per cycle while the result is taken (at most MAX_RESULTS); a tick with no wake gives one result.
// One request in flight at a time; the token's walk through the cells and the pop state set the rate.
// Reset clears the tick count, the queued bits and every cell's occupancy.
module delta_sleep_timer_queue (
	input  logic         clk,
	input  logic         arst_n,
	dstq_in_if.sink      req,
	dstq_out_if.source   rsp
);

	dstq_pkg::entry_t    ent  [dstq_pkg::THREADS];
	dstq_pkg::tok_t      toks [dstq_pkg::THREADS];
	dstq_pkg::tok_t      launch;
	dstq_pkg::head_ctl_t hctl;
	logic                busy;

	// Any token still moving down the chain blocks new requests
	always_comb begin
		busy = 1'b0;
		for (int k = 0; k < dstq_pkg::THREADS; k++) begin
			busy = busy | toks[k].valid;
		end
	end

	dstq_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp),
		.head   (ent[0]),
		.second (ent[1]),
		.busy   (busy),
		.launch (launch),
		.hctl   (hctl)
	);

	// Chain of list cells, head at index 0
	for (genvar k = 0; k < dstq_pkg::THREADS; k++) begin : g_cell
		dstq_pkg::tok_t   tok_in;
		dstq_pkg::entry_t right;
		logic             dec;

		if (k == 0) begin : g_head
			assign tok_in = launch;
			assign dec    = hctl.dec;
		end else begin : g_body
			assign tok_in = toks[k-1];
			assign dec    = 1'b0;
		end

		if (k == dstq_pkg::THREADS - 1) begin : g_tail
			assign right = '0;
		end else begin : g_link
			assign right = ent[k+1];
		end

		dstq_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.tok_in  (tok_in),
			.right   (right),
			.pop     (hctl.pop),
			.dec     (dec),
			.entry   (ent[k]),
			.tok_out (toks[k])
		);
	end

endmodule

@@ hw/rtl/dstq_cell.sv @@
`timescale 1ns / 1ps

module dstq_cell (
	input  logic              clk,
	input  logic              arst_n,
	input  dstq_pkg::tok_t    tok_in,
	input  dstq_pkg::entry_t  right,
	input  logic              pop,
	input  logic              dec,
	output dstq_pkg::entry_t  entry,
	output dstq_pkg::tok_t    tok_out
);

	logic                        valid_q;
	logic [dstq_pkg::ID_W-1:0]   id_q;
	logic [dstq_pkg::TICK_W-1:0] delta_q;
	dstq_pkg::tok_t              tok_q;

	logic                        take;
	logic [dstq_pkg::ID_W-1:0]   new_id;
	logic [dstq_pkg::TICK_W-1:0] new_delta;
	dstq_pkg::tok_t              tok_nx;

	// Token handling: settle here, displace, or pass on with the remainder
	always_comb begin
		take      = 1'b0;
		new_id    = tok_in.id;
		new_delta = tok_in.t;
		tok_nx    = '0;
		if (tok_in.valid) begin
			if (!valid_q || tok_in.disp) begin
				take = 1'b1;
				if (valid_q) begin
					tok_nx = '{valid: 1'b1, disp: 1'b1, id: id_q, t: delta_q};
				end
			end else if (tok_in.t < delta_q) begin
				take   = 1'b1;
				tok_nx = '{valid: 1'b1, disp: 1'b1, id: id_q, t: delta_q - tok_in.t};
			end else begin
				tok_nx = '{valid: 1'b1, disp: 1'b0, id: tok_in.id, t: tok_in.t - delta_q};
			end
		end
	end

	// Occupancy and outgoing token
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			tok_q   <= '0;
		end else begin
			tok_q <= tok_nx;
			if (pop) begin
				valid_q <= right.valid;
			end else if (take) begin
				valid_q <= 1'b1;
			end
		end
	end

	// Entry payload
	always_ff @(posedge clk) begin
		if (pop) begin
			id_q    <= right.id;
			delta_q <= right.delta;
		end else if (take) begin
			id_q    <= new_id;
			delta_q <= new_delta;
		end else if (dec) begin
			delta_q <= delta_q - dstq_pkg::TICK_W'(1);
		end
	end

	assign entry   = '{valid: valid_q, id: id_q, delta: delta_q};
	assign tok_out = tok_q;

endmodule

@@ hw/rtl/dstq_ctrl.sv @@
`timescale 1ns / 1ps

module dstq_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	dstq_in_if.sink               req,
	dstq_out_if.source            rsp,
	input  dstq_pkg::entry_t      head,
	input  dstq_pkg::entry_t      second,
	input  logic                  busy,
	output dstq_pkg::tok_t        launch,
	output dstq_pkg::head_ctl_t   hctl
);

	dstq_pkg::state_t            state_q, state_nx;
	logic [dstq_pkg::TICK_W-1:0] tick_count_q;
	logic [dstq_pkg::THREADS-1:0] queued_q;
	logic [dstq_pkg::CNT_W-1:0]  pop_cnt_q;
	logic                        rsp_valid_q;
	dstq_pkg::kind_t             kind_q, kind_nx;
	logic [dstq_pkg::ID_W-1:0]   woken_q, woken_nx;
	logic                        last_q, last_nx;

	logic                        slot_free;
	logic                        acc;
	logic                        emit;
	logic                        can_pop;
	logic                        pop_last;
	logic                        ins_ok;
	logic [dstq_pkg::CMP_W-1:0]  req_id_ext;
	logic [dstq_pkg::CMP_W-1:0]  head_id_ext;
	logic [dstq_pkg::IDX_W-1:0]  req_idx;
	logic [dstq_pkg::IDX_W-1:0]  head_idx;

	// Thread id range check and queued-bit index
	assign req_id_ext  = dstq_pkg::CMP_W'(req.thread_id);
	assign head_id_ext = dstq_pkg::CMP_W'(head.id);
	assign req_idx     = req_id_ext[dstq_pkg::IDX_W-1:0];
	assign head_idx    = head_id_ext[dstq_pkg::IDX_W-1:0];

	assign slot_free = !rsp_valid_q || rsp.ready;
	assign acc       = req.valid && req.ready;
	assign ins_ok    = (req.ticks != '0)
		&& (req_id_ext < dstq_pkg::CMP_W'(dstq_pkg::THREADS))
		&& !queued_q[req_idx];
	assign can_pop   = head.valid && (head.delta == '0);
	assign pop_last  = (pop_cnt_q == dstq_pkg::CNT_W'(dstq_pkg::MAX_RESULTS - 1))
		|| !second.valid || (second.delta != '0);

	// Next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			dstq_pkg::ST_IDLE: begin
				if (acc && req.op) begin
					state_nx = dstq_pkg::ST_POP;
				end
			end
			dstq_pkg::ST_POP: begin
				if (slot_free && (!can_pop || pop_last)) begin
					state_nx = dstq_pkg::ST_IDLE;
				end
			end
			default: state_nx = dstq_pkg::ST_IDLE;
		endcase
	end

	// Outputs of the state machine
	always_comb begin
		req.ready = 1'b0;
		launch    = '0;
		hctl      = '0;
		emit      = 1'b0;
		kind_nx   = dstq_pkg::KIND_ACK;
		woken_nx  = '0;
		last_nx   = 1'b1;
		unique case (state_q)
			dstq_pkg::ST_IDLE: begin
				req.ready = slot_free && !busy;
				if (acc && !req.op) begin
					emit   = 1'b1;
					launch = '{valid: ins_ok, disp: 1'b0, id: req.thread_id, t: req.ticks};
				end
				hctl.dec = acc && req.op && head.valid && (head.delta != '0);
			end
			dstq_pkg::ST_POP: begin
				if (slot_free) begin
					emit = 1'b1;
					if (can_pop) begin
						hctl.pop = 1'b1;
						kind_nx  = dstq_pkg::KIND_WAKE;
						woken_nx = head.id;
						last_nx  = pop_last;
					end else begin
						kind_nx  = dstq_pkg::KIND_IDLE;
					end
				end
			end
			default: ;
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= dstq_pkg::ST_IDLE;
			tick_count_q <= '0;
			queued_q     <= '0;
			pop_cnt_q    <= '0;
			rsp_valid_q  <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (emit) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			if (acc && req.op) begin
				tick_count_q <= tick_count_q + dstq_pkg::TICK_W'(1);
				pop_cnt_q    <= '0;
			end else if (hctl.pop) begin
				pop_cnt_q <= pop_cnt_q + dstq_pkg::CNT_W'(1);
			end
			if (launch.valid) begin
				queued_q[req_idx] <= 1'b1;
			end else if (hctl.pop) begin
				queued_q[head_idx] <= 1'b0;
			end
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (emit) begin
			kind_q  <= kind_nx;
			woken_q <= woken_nx;
			last_q  <= last_nx;
		end
	end

	// Tick count only moves on a tick request, after the previous result is gone
	assign rsp.valid        = rsp_valid_q;
	assign rsp.kind         = kind_q;
	assign rsp.woken_thread = woken_q;
	assign rsp.time_now     = tick_count_q;
	assign rsp.last         = last_q;

endmodule
